@@ design/max_heap_priority_queue_defines.svh @@
// Assertion macros for the max-heap priority queue checker.
// Both expect clk_i and rst_ni in scope.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication.
`define MHPQ_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define MHPQ_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

@@ design/mhpq_pkg.sv @@
package mhpq_pkg;

  // Heap positions are 1-based; 17 bits cover the largest supported capacity.
  localparam int unsigned POS_W   = 17;
  localparam int unsigned DEPTH_W = 5;
  localparam int unsigned OCC_W   = 11;

  typedef logic signed [31:0] val_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam val_t EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic kind;
    val_t value;
  } item_t;

  typedef struct packed {
    val_t             max_value;
    logic [1:0]       status;
    logic [OCC_W-1:0] occupancy;
  } result_t;

  typedef enum logic {
    OP_INSERT,
    OP_SIFT
  } op_e;

  // Work handed from one level cell to the next.
  typedef struct packed {
    logic   valid;
    op_e    op;
    val_t   data;
    pos_t   pos;
    pos_t   limit;
    depth_t depth;
  } token_t;

  typedef struct packed {
    logic en;
    pos_t pos;
  } rd_req_t;

  typedef struct packed {
    val_t even;
    val_t odd;
  } row_t;

  typedef enum logic [1:0] {
    CELL_IDLE,
    CELL_INS_RD,
    CELL_SIFT_RD
  } cell_state_e;

  typedef enum logic [2:0] {
    CTL_IDLE,
    CTL_LAUNCH,
    CTL_ROOT,
    CTL_LAST,
    CTL_FETCH,
    CTL_WALK
  } ctl_state_e;

  // Level of a 1-based heap position.
  function automatic depth_t msb_index(pos_t p);
    depth_t idx;
    idx = '0;
    for (int i = 0; i < POS_W; i++) begin
      if (p[i]) begin
        idx = DEPTH_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

@@ design/mhpq_cell.sv @@
module mhpq_cell #(
  parameter int unsigned LEVEL = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mhpq_pkg::token_t  tok_i,
  output mhpq_pkg::token_t  tok_o,
  input  mhpq_pkg::rd_req_t up_req_i,
  input  mhpq_pkg::rd_req_t ctl_req_i,
  output mhpq_pkg::row_t    rd_row_o,
  output mhpq_pkg::rd_req_t down_req_o,
  input  mhpq_pkg::row_t    down_row_i,
  output logic             done_o
);
  import mhpq_pkg::*;

  // Level L holds 2^L nodes, stored as sibling pairs (even / odd position).
  localparam int unsigned ROWS  = (LEVEL < 2) ? 1 : (1 << (LEVEL - 1));
  localparam int unsigned ROW_W = (ROWS < 2) ? 1 : $clog2(ROWS);

  function automatic logic [ROW_W-1:0] row_of(pos_t p);
    return ROW_W'((p >> 1) & pos_t'(ROWS - 1));
  endfunction

  function automatic logic odd_of(pos_t p);
    return (LEVEL != 0) && p[0];
  endfunction

  cell_state_e state_q, state_d;
  token_t      tok_q, tok_d;

  logic [POS_W:0] in_left;
  logic [POS_W:0] q_right;
  logic [DEPTH_W-1:0] shamt;
  pos_t  path;
  val_t  node;
  val_t  best;
  logic  pick_r;

  logic  own_rd;
  logic  we;
  pos_t  wr_pos;
  val_t  wr_val;
  logic  rd_en;
  pos_t  rd_pos;

  val_t  mem_even_q [ROWS];
  val_t  mem_odd_q  [ROWS];
  row_t  rd_row_q;

  assign rd_row_o = rd_row_q;

  assign in_left = {tok_i.pos, 1'b0};
  assign q_right = {tok_q.pos, 1'b1};
  assign shamt   = tok_q.depth - DEPTH_W'(LEVEL) - DEPTH_W'(1);
  assign path    = tok_q.limit >> shamt;
  assign node    = odd_of(tok_q.pos) ? rd_row_q.odd : rd_row_q.even;
  assign pick_r  = (q_right <= {1'b0, tok_q.limit}) && (down_row_i.odd > down_row_i.even);
  assign best    = pick_r ? down_row_i.odd : down_row_i.even;

  always_comb begin
    state_d    = state_q;
    tok_d      = tok_q;
    tok_o      = '0;
    down_req_o = '0;
    done_o     = 1'b0;
    own_rd     = 1'b0;
    we         = 1'b0;
    wr_pos     = tok_q.pos;
    wr_val     = tok_q.data;
    unique case (state_q)
      CELL_IDLE: begin
        if (tok_i.valid) begin
          tok_d  = tok_i;
          wr_pos = tok_i.pos;
          wr_val = tok_i.data;
          if (tok_i.op == OP_INSERT) begin
            if (tok_i.pos == tok_i.limit) begin
              // new leaf: drop the carried value here
              we     = 1'b1;
              done_o = 1'b1;
            end else begin
              own_rd  = 1'b1;
              state_d = CELL_INS_RD;
            end
          end else begin
            if (in_left > {1'b0, tok_i.limit}) begin
              we     = 1'b1;
              done_o = 1'b1;
            end else begin
              down_req_o.en  = 1'b1;
              down_req_o.pos = POS_W'(in_left);
              state_d        = CELL_SIFT_RD;
            end
          end
        end
      end
      CELL_INS_RD: begin
        // keep the larger value at this level, push the smaller one down
        tok_o.valid = 1'b1;
        tok_o.op    = OP_INSERT;
        tok_o.pos   = {tok_q.pos[POS_W-2:0], path[0]};
        tok_o.limit = tok_q.limit;
        tok_o.depth = tok_q.depth;
        if (tok_q.data > node) begin
          we         = 1'b1;
          tok_o.data = node;
        end else begin
          tok_o.data = tok_q.data;
        end
        state_d = CELL_IDLE;
      end
      CELL_SIFT_RD: begin
        we = 1'b1;
        if (best > tok_q.data) begin
          // promote the larger child, follow it down
          wr_val      = best;
          tok_o.valid = 1'b1;
          tok_o.op    = OP_SIFT;
          tok_o.data  = tok_q.data;
          tok_o.pos   = {tok_q.pos[POS_W-2:0], pick_r};
          tok_o.limit = tok_q.limit;
          tok_o.depth = tok_q.depth;
        end else begin
          done_o = 1'b1;
        end
        state_d = CELL_IDLE;
      end
      default: begin
        state_d = CELL_IDLE;
      end
    endcase
  end

  assign rd_en  = own_rd | up_req_i.en | ctl_req_i.en;
  assign rd_pos = own_rd ? tok_i.pos : (up_req_i.en ? up_req_i.pos : ctl_req_i.pos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CELL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      if (odd_of(wr_pos)) begin
        mem_odd_q[row_of(wr_pos)] <= wr_val;
      end else begin
        mem_even_q[row_of(wr_pos)] <= wr_val;
      end
    end
    if (rd_en) begin
      rd_row_q.even <= mem_even_q[row_of(rd_pos)];
      rd_row_q.odd  <= mem_odd_q[row_of(rd_pos)];
    end
  end

endmodule

@@ design/max_heap_priority_queue.sv @@
// Binary max-heap priority queue of signed 32-bit values, one level cell per heap
// level, each with its own level memory. Pulse start while busy is low to hand over
// an insert or an extract-max; exactly one result follows on result_o with a
// one-cycle result_valid_o strobe, which the receiver must take as it comes. An
// insert walks from the root to the new leaf one level per cycle: a cell reads its
// node, then compares and writes in the next cycle, while the cell below already
// reads. An extract first reads the root and the last element in turn, then sifts
// down one level per cycle the same way. Refused inserts and extracts from an
// empty queue are answered straight from idle, without busy going high. start may
// be raised again in the cycle the strobe is shown. No clearing pass is needed
// after reset.
module max_heap_priority_queue #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  mhpq_pkg::item_t   item_i,
  output logic              busy,
  output logic              result_valid_o,
  output mhpq_pkg::result_t result_o
);
  import mhpq_pkg::*;

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned LEVELS = CNT_W;
  localparam int unsigned LVL_W  = $clog2(LEVELS);

  ctl_state_e       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  val_t             val_q, val_d;
  val_t             max_q, max_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  result_t          res_q, res_d;
  logic             res_valid_q, res_valid_d;

  token_t  tok0;
  logic    ctl_en;
  depth_t  ctl_lvl;
  pos_t    ctl_pos;
  pos_t    cnt_pos;
  depth_t  cnt_lvl;
  val_t    last_val;

  token_t  tok_in   [LEVELS];
  token_t  tok_out  [LEVELS];
  rd_req_t up_req   [LEVELS];
  rd_req_t down_req [LEVELS];
  rd_req_t ctl_req  [LEVELS];
  row_t    cell_row [LEVELS];
  row_t    down_row [LEVELS];
  logic [LEVELS-1:0] done;

  assign cnt_pos  = POS_W'(count_q);
  assign cnt_lvl  = msb_index(cnt_pos);
  assign last_val = ((lvl_q != '0) && count_q[0]) ? cell_row[lvl_q].odd
                                                   : cell_row[lvl_q].even;

  assign busy           = (state_q != CTL_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    val_d       = val_q;
    max_d       = max_q;
    lvl_d       = lvl_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    tok0        = '0;
    ctl_en      = 1'b0;
    ctl_lvl     = '0;
    ctl_pos     = pos_t'(1);
    unique case (state_q)
      CTL_IDLE: begin
        if (start) begin
          if (item_i.kind == KIND_INSERT) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              res_d       = '{max_value: '0, status: STATUS_FULL, occupancy: OCC_W'(count_q)};
              res_valid_d = 1'b1;
            end else begin
              count_d = count_q + CNT_W'(1);
              val_d   = item_i.value;
              max_d   = '0;
              state_d = CTL_LAUNCH;
            end
          end else begin
            if (count_q == '0) begin
              res_d       = '{max_value: EMPTY_VALUE, status: STATUS_EMPTY,
                              occupancy: OCC_W'(count_q)};
              res_valid_d = 1'b1;
            end else begin
              state_d = CTL_ROOT;
            end
          end
        end
      end
      CTL_LAUNCH: begin
        // count already holds the new size, which is the new leaf position
        tok0    = '{valid: 1'b1, op: OP_INSERT, data: val_q, pos: pos_t'(1),
                    limit: cnt_pos, depth: cnt_lvl};
        if (count_q == CNT_W'(1)) begin
          // the root is the new leaf: the value lands in this cycle
          res_d       = '{max_value: '0, status: STATUS_OK, occupancy: OCC_W'(count_q)};
          res_valid_d = 1'b1;
          state_d     = CTL_IDLE;
        end else begin
          state_d = CTL_WALK;
        end
      end
      CTL_ROOT: begin
        ctl_en  = 1'b1;
        state_d = CTL_LAST;
      end
      CTL_LAST: begin
        max_d   = cell_row[0].even;
        ctl_en  = 1'b1;
        ctl_lvl = cnt_lvl;
        ctl_pos = cnt_pos;
        lvl_d   = LVL_W'(cnt_lvl);
        state_d = CTL_FETCH;
      end
      CTL_FETCH: begin
        count_d = count_q - CNT_W'(1);
        if (count_q == CNT_W'(1)) begin
          res_d       = '{max_value: max_q, status: STATUS_OK, occupancy: '0};
          res_valid_d = 1'b1;
          state_d     = CTL_IDLE;
        end else begin
          // move the last element to the root and sift it down
          tok0    = '{valid: 1'b1, op: OP_SIFT, data: last_val, pos: pos_t'(1),
                      limit: cnt_pos - pos_t'(1), depth: '0};
          if (count_q == CNT_W'(2)) begin
            // the root has no children left: it is written in this cycle
            res_d       = '{max_value: max_q, status: STATUS_OK, occupancy: OCC_W'(count_d)};
            res_valid_d = 1'b1;
            state_d     = CTL_IDLE;
          end else begin
            state_d = CTL_WALK;
          end
        end
      end
      CTL_WALK: begin
        if (|done) begin
          res_d       = '{max_value: max_q, status: STATUS_OK, occupancy: OCC_W'(count_q)};
          res_valid_d = 1'b1;
          state_d     = CTL_IDLE;
        end
      end
      default: begin
        state_d = CTL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTL_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    max_q <= max_d;
    lvl_q <= lvl_d;
    res_q <= res_d;
  end

  for (genvar l = 0; l < LEVELS; l++) begin : g_cell
    assign ctl_req[l].en  = ctl_en && (ctl_lvl == DEPTH_W'(l));
    assign ctl_req[l].pos = ctl_pos;

    if (l == 0) begin : g_head
      assign tok_in[l] = tok0;
      assign up_req[l] = '0;
    end else begin : g_link
      assign tok_in[l] = tok_out[l-1];
      assign up_req[l] = down_req[l-1];
    end

    if (l == LEVELS - 1) begin : g_tail
      assign down_row[l] = '0;
    end else begin : g_next
      assign down_row[l] = cell_row[l+1];
    end

    mhpq_cell #(
      .LEVEL(l)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tok_i      (tok_in[l]),
      .tok_o      (tok_out[l]),
      .up_req_i   (up_req[l]),
      .ctl_req_i  (ctl_req[l]),
      .rd_row_o   (cell_row[l]),
      .down_req_o (down_req[l]),
      .down_row_i (down_row[l]),
      .done_o     (done[l])
    );
  end

endmodule

@@ design/mhpq_checker.sv @@
module mhpq_checker #(
  parameter int unsigned CAPACITY = 1024
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input mhpq_pkg::item_t   item_i,
  input logic              busy,
  input logic              result_valid_o,
  input mhpq_pkg::result_t result_o
);
  import mhpq_pkg::*;
  `include "max_heap_priority_queue_defines.svh"

  // A refused insert reports a full queue.
  `MHPQ_ASSERT_IMP(a_full_occ, result_valid_o && (result_o.status == STATUS_FULL), result_o.occupancy == OCC_W'(CAPACITY))
  // An empty extract returns -1 and leaves the queue empty.
  `MHPQ_ASSERT_IMP(a_empty_res, result_valid_o && (result_o.status == STATUS_EMPTY), (result_o.max_value == EMPTY_VALUE) && (result_o.occupancy == '0))
  // An accepted transaction either answers at once or keeps the block busy.
  `MHPQ_ASSERT_NEXT(a_accept_resp, start && !busy && (item_i.kind == KIND_INSERT || item_i.kind == KIND_EXTRACT), busy || result_valid_o)
  // Results only appear once the block is free again.
  `MHPQ_ASSERT_IMP(a_strobe_idle, result_valid_o, !busy)

endmodule

bind max_heap_priority_queue mhpq_checker #(
  .CAPACITY(CAPACITY)
) u_mhpq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .item_i         (item_i),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
